// ===== rtl/scp_pkg.sv =====
// shared types, codes and constants for the stream pattern censor
// no dependencies; every other rtl file refers to it by scoped names
package scp_pkg;

   localparam int ACTION_W = 2;
   localparam int CHAR_W = 8;
   localparam int POS_W = 12;
   localparam int KEPT_W = 13;
   localparam int LEN_W = 5;
   localparam int PAT_BYTES = 16;
   localparam int PAT_IDX_W = 4;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam int DEF_STACK_DEPTH = 4096;
   localparam int DEF_MAX_PATTERN = 16;

   // action codes on the request channel
   localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   // register indexes, taken from paddr[4:3]
   localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
   localparam logic [1:0] REG_PATTERN_LOW = 2'd1;
   localparam logic [1:0] REG_PATTERN_HIGH = 2'd2;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_READ,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MATCH
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   char_value;
      logic [POS_W-1:0]    position;
      logic                pos_in_depth;
   } item_type;

   typedef struct packed {
      logic [LEN_W-1:0]                  length;
      logic [PAT_BYTES-1:0][CHAR_W-1:0]  bytes;
   } cfg_type;

   typedef struct packed {
      logic [KEPT_W-1:0]   kept_length;
      logic                removed;
      logic [CHAR_W-1:0]   read_char;
      logic                read_valid;
      logic                overflow;
   } rsp_type;

endpackage

// ===== rtl/scp_if.sv =====
// request and response stream interfaces with valid/ready handshake
// depends on scp_pkg for field widths
interface scp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [scp_pkg::ACTION_W-1:0]         action;
   logic [scp_pkg::CHAR_W-1:0]           char_value;
   logic [scp_pkg::POS_W-1:0]            position;

   modport source (output valid, output action, output char_value, output position,
      input ready);
   modport sink (input valid, input action, input char_value, input position,
      output ready);
endinterface

interface scp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [scp_pkg::KEPT_W-1:0]           kept_length;
   logic                                 removed;
   logic [scp_pkg::CHAR_W-1:0]           read_char;
   logic                                 read_valid;
   logic                                 overflow;

   modport source (output valid, output kept_length, output removed, output read_char,
      output read_valid, output overflow, input ready);
   modport sink (input valid, input kept_length, input removed, input read_char,
      input read_valid, input overflow, output ready);
endinterface

// ===== rtl/stream_pattern_censor.sv =====
// Stream pattern censor. Text bytes pushed on the request channel go onto a kept-text
// stack held in a single-port-read memory; after each push the top pattern_length bytes
// are compared with the configured pattern and popped on a match, so occurrences formed
// by earlier removals are removed too. A push that needs no compare, a clear, an unused
// action and an out-of-range read are answered from IDLE in the back end; an in-range read
// passes through READ, and a push that compares stays in MATCH while the compare reads one
// stored byte per cycle through the memory's read port. A two-entry request queue and a
// result register let the request and response sides stall independently.
// The store needs no clearing pass after reset; only bytes below the kept count are read.
// top level: instantiates scp_csr, scp_front and scp_back; depends on scp_pkg, scp_if
module stream_pattern_censor #(
   parameter int STACK_DEPTH = scp_pkg::DEF_STACK_DEPTH,
   parameter int MAX_PATTERN = scp_pkg::DEF_MAX_PATTERN
) (
   input  logic                              clock,
   input  logic                              reset,
   scp_req_if.sink                           req,
   scp_rsp_if.source                         rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [scp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [scp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [scp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   scp_pkg::cfg_type    cfg;
   logic                q_valid;
   scp_pkg::item_type   q_item;
   logic                q_pop;

   scp_csr #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   scp_front #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   scp_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

// ===== rtl/scp_csr.sv =====
// apb-style register block holding the pattern length and pattern bytes
// depends on scp_pkg
module scp_csr #(
   parameter int MAX_PATTERN = scp_pkg::DEF_MAX_PATTERN
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [scp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [scp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [scp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output scp_pkg::cfg_type                  cfg
);

   logic [scp_pkg::LEN_W-1:0]       length_ff;
   logic [scp_pkg::CSR_DATA_W-1:0]  low_ff;
   logic [scp_pkg::CSR_DATA_W-1:0]  high_ff;
   logic                            wr_en;
   logic [1:0]                      reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx = csr_paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= scp_pkg::LEN_W'(1);
         low_ff <= '0;
         high_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            scp_pkg::REG_PATTERN_LENGTH: length_ff <= csr_pwdata[scp_pkg::LEN_W-1:0];
            scp_pkg::REG_PATTERN_LOW: low_ff <= csr_pwdata;
            scp_pkg::REG_PATTERN_HIGH: high_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         scp_pkg::REG_PATTERN_LENGTH: csr_prdata = scp_pkg::CSR_DATA_W'(length_ff);
         scp_pkg::REG_PATTERN_LOW: csr_prdata = low_ff;
         scp_pkg::REG_PATTERN_HIGH: csr_prdata = high_ff;
         default: csr_prdata = '0;
      endcase
   end

   // lengths above the supported maximum saturate
   always_comb begin
      cfg.length = (length_ff > scp_pkg::LEN_W'(MAX_PATTERN)) ?
         scp_pkg::LEN_W'(MAX_PATTERN) : length_ff;
      cfg.bytes = {high_ff, low_ff};
   end

endmodule

// ===== rtl/scp_front.sv =====
// front end: accepts requests, decodes the action and queues them for the back end
// depends on scp_pkg and scp_req_if
module scp_front #(
   parameter int STACK_DEPTH = scp_pkg::DEF_STACK_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   scp_req_if.sink             req,
   output logic                q_valid,
   output scp_pkg::item_type   q_item,
   input  logic                q_pop
);

   scp_pkg::item_type                     queue_ff [scp_pkg::QUEUE_DEPTH];
   logic [scp_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff;
   logic [scp_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff;
   logic [scp_pkg::QUEUE_CNT_W-1:0]       fill_ff;
   logic [scp_pkg::QUEUE_CNT_W-1:0]       fill_in;
   logic                                  push;
   scp_pkg::item_type                     item_in;

   assign req.ready = (fill_ff != scp_pkg::QUEUE_CNT_W'(scp_pkg::QUEUE_DEPTH));
   assign push = req.valid && req.ready;
   assign q_valid = (fill_ff != '0);
   assign q_item = queue_ff[rd_ptr_ff];

   always_comb begin
      unique case (req.action)
         scp_pkg::ACT_PUSH: item_in.op = scp_pkg::OP_PUSH;
         scp_pkg::ACT_READ: item_in.op = scp_pkg::OP_READ;
         scp_pkg::ACT_CLEAR: item_in.op = scp_pkg::OP_CLEAR;
         default: item_in.op = scp_pkg::OP_NONE;
      endcase
      item_in.char_value = req.char_value;
      item_in.position = req.position;
      item_in.pos_in_depth = (32'(req.position) < 32'(STACK_DEPTH));
   end

   always_comb begin
      fill_in = fill_ff;
      if (push && !q_pop) begin
         fill_in = fill_ff + scp_pkg::QUEUE_CNT_W'(1);
      end else if (!push && q_pop) begin
         fill_in = fill_ff - scp_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + scp_pkg::QUEUE_PTR_W'(1);
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + scp_pkg::QUEUE_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// ===== rtl/scp_back.sv =====
// back end: kept-text memory, stack count, pattern compare sequencer and result register
// depends on scp_pkg and scp_rsp_if
module scp_back #(
   parameter int STACK_DEPTH = scp_pkg::DEF_STACK_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  scp_pkg::cfg_type    cfg,
   input  logic                q_valid,
   input  scp_pkg::item_type   q_item,
   output logic                q_pop,
   scp_rsp_if.source           rsp
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int PW = (CW > scp_pkg::POS_W) ? CW : scp_pkg::POS_W;

   logic [scp_pkg::CHAR_W-1:0]      kept_text_ff [STACK_DEPTH];
   logic [scp_pkg::CHAR_W-1:0]      rd_data_ff;

   scp_pkg::state_type              state_ff;
   scp_pkg::state_type              state_in;
   logic [CW-1:0]                   count_ff;
   logic [CW-1:0]                   count_in;
   logic [CW-1:0]                   base_ff;
   logic [CW-1:0]                   base_in;
   logic [scp_pkg::LEN_W-1:0]       issue_ff;
   logic [scp_pkg::LEN_W-1:0]       issue_in;
   logic [scp_pkg::PAT_IDX_W-1:0]   cmp_idx_ff;
   logic [scp_pkg::PAT_IDX_W-1:0]   cmp_idx_in;
   logic                            cmp_valid_ff;
   logic                            cmp_valid_in;
   logic                            rsp_valid_ff;
   scp_pkg::rsp_type                rsp_data_ff;
   scp_pkg::rsp_type                res_in;
   logic                            res_load;

   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic                            rd_en;
   logic [AW-1:0]                   rd_addr;

   logic                            slot_free;
   logic                            full;
   logic [CW-1:0]                   count_inc;
   logic                            start_match;
   logic                            read_hit;
   logic                            mismatch;
   logic                            last;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign q_pop = (state_ff == scp_pkg::ST_IDLE) && q_valid && slot_free;
   assign full = (count_ff == CW'(STACK_DEPTH));
   assign count_inc = count_ff + CW'(1);
   assign start_match = (cfg.length != '0) && (count_inc >= CW'(cfg.length));
   assign read_hit = q_item.pos_in_depth && (PW'(q_item.position) < PW'(count_ff));
   assign mismatch = (rd_data_ff != cfg.bytes[cmp_idx_ff]);
   assign last = (cmp_idx_ff == scp_pkg::PAT_IDX_W'(cfg.length - scp_pkg::LEN_W'(1)));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scp_pkg::ST_IDLE: begin
            if (q_pop) begin
               if (q_item.op == scp_pkg::OP_PUSH && !full && start_match) begin
                  state_in = scp_pkg::ST_MATCH;
               end else if (q_item.op == scp_pkg::OP_READ && read_hit) begin
                  state_in = scp_pkg::ST_READ;
               end
            end
         end
         scp_pkg::ST_READ: state_in = scp_pkg::ST_IDLE;
         scp_pkg::ST_MATCH: begin
            if (cmp_valid_ff && (mismatch || last)) begin
               state_in = scp_pkg::ST_IDLE;
            end
         end
         default: state_in = scp_pkg::ST_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      count_in = count_ff;
      base_in = base_ff;
      issue_in = issue_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_valid_in = 1'b0;
      wr_en = 1'b0;
      wr_addr = AW'(count_ff);
      rd_en = 1'b0;
      rd_addr = AW'(q_item.position);
      res_load = 1'b0;
      res_in = '0;
      res_in.kept_length = scp_pkg::KEPT_W'(count_ff);
      unique case (state_ff)
         scp_pkg::ST_IDLE: begin
            if (q_pop) begin
               case (q_item.op)
                  scp_pkg::OP_PUSH: begin
                     if (full) begin
                        res_load = 1'b1;
                        res_in.overflow = 1'b1;
                     end else begin
                        wr_en = 1'b1;
                        count_in = count_inc;
                        if (start_match) begin
                           // compare the top pattern_length bytes, oldest first
                           base_in = count_inc - CW'(cfg.length);
                           issue_in = '0;
                        end else begin
                           res_load = 1'b1;
                           res_in.kept_length = scp_pkg::KEPT_W'(count_inc);
                        end
                     end
                  end
                  scp_pkg::OP_READ: begin
                     if (read_hit) begin
                        rd_en = 1'b1;
                     end else begin
                        res_load = 1'b1;
                     end
                  end
                  scp_pkg::OP_CLEAR: begin
                     count_in = '0;
                     res_load = 1'b1;
                     res_in.kept_length = '0;
                  end
                  default: res_load = 1'b1;
               endcase
            end
         end
         scp_pkg::ST_READ: begin
            res_load = 1'b1;
            res_in.read_valid = 1'b1;
            res_in.read_char = rd_data_ff;
         end
         scp_pkg::ST_MATCH: begin
            // one memory read issued per cycle, compared the cycle after
            rd_addr = AW'(base_ff + CW'(issue_ff));
            rd_en = (issue_ff < cfg.length);
            cmp_valid_in = rd_en;
            cmp_idx_in = scp_pkg::PAT_IDX_W'(issue_ff);
            issue_in = issue_ff + scp_pkg::LEN_W'(1);
            if (cmp_valid_ff) begin
               if (mismatch) begin
                  res_load = 1'b1;
                  rd_en = 1'b0;
                  cmp_valid_in = 1'b0;
               end else if (last) begin
                  res_load = 1'b1;
                  count_in = base_ff;
                  res_in.kept_length = scp_pkg::KEPT_W'(base_ff);
                  res_in.removed = 1'b1;
                  rd_en = 1'b0;
                  cmp_valid_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scp_pkg::ST_IDLE;
         count_ff <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      issue_ff <= issue_in;
      cmp_idx_ff <= cmp_idx_in;
      if (res_load) begin
         rsp_data_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         kept_text_ff[wr_addr] <= q_item.char_value;
      end
      if (rd_en) begin
         rd_data_ff <= kept_text_ff[rd_addr];
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.kept_length = rsp_data_ff.kept_length;
   assign rsp.removed = rsp_data_ff.removed;
   assign rsp.read_char = rsp_data_ff.read_char;
   assign rsp.read_valid = rsp_data_ff.read_valid;
   assign rsp.overflow = rsp_data_ff.overflow;

endmodule

// ===== rtl/scp_checker.sv =====
// port-level checker for stream_pattern_censor, attached by the bind at the end
// depends on scp_pkg
module scp_checker #(
   parameter int STACK_DEPTH = scp_pkg::DEF_STACK_DEPTH
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [scp_pkg::KEPT_W-1:0]      rsp_kept_length,
   input logic                            rsp_removed,
   input logic [scp_pkg::CHAR_W-1:0]      rsp_read_char,
   input logic                            rsp_read_valid,
   input logic                            rsp_overflow
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kept_length)
         && $stable(rsp_removed) && $stable(rsp_read_char))
      else $error("response changed while stalled");

   // removal, read hit and overflow come from different actions
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_removed, rsp_read_valid, rsp_overflow}) <= 1)
      else $error("more than one response flag set");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_valid |-> rsp_read_char == '0)
      else $error("read_char nonzero without a read hit");

   // a dropped push only happens on a full store
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_kept_length == scp_pkg::KEPT_W'(STACK_DEPTH))
      else $error("overflow with store not full");

endmodule

bind stream_pattern_censor scp_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_scp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_kept_length (rsp.kept_length),
   .rsp_removed     (rsp.removed),
   .rsp_read_char   (rsp.read_char),
   .rsp_read_valid  (rsp.read_valid),
   .rsp_overflow    (rsp.overflow)
);

// ===== verif/tb_stream_pattern_censor.sv =====
// testbench for stream_pattern_censor: directed rows and random nested-pattern
// traffic, every result checked against a typed row or an in-bench censor predictor
// depends on scp_pkg, scp_if and the rtl of the block
module tb_stream_pattern_censor;
   timeunit 1ns;
   timeprecision 1ps;
   import scp_pkg::*;

   localparam int STACK_SIZE = DEF_STACK_DEPTH;
   localparam int PATTERN_MAX = DEF_MAX_PATTERN;
   localparam int LIMIT_CYCLES = 400000;
   localparam int LONG_STALL_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;
   localparam int MAX_REPORTS = 10;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [1:0]            reg_idx;
      logic [63:0]           reg_value;
      logic [ACTION_W-1:0]   action;
      logic [CHAR_W-1:0]     char_value;
      logic [POS_W-1:0]      position;
      logic                  typed;
      rsp_type               want;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   scp_req_if req_ch();
   scp_rsp_if rsp_ch();

   stream_pattern_censor u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state and its copy of the registers
   logic [CHAR_W-1:0] kept_store [STACK_SIZE];
   int                kept_total;
   logic [LEN_W-1:0]  pat_len;
   logic [63:0]       pat_low;
   logic [63:0]       pat_high;

   rsp_type          expected_rsp_q [$];
   directed_row_type directed_rows [$];
   int               open_matches [$];

   int  mismatch_count;
   int  results_checked;
   int  requests_sent;
   int  predicted_removals;
   int  predicted_overflows;
   int  valid_reads;
   int  clears_sent;
   int  cycle_count = 0;
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  long_stall;
   event start_long_stall;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic void note_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("MISMATCH at %0t: %s", $realtime, msg);
   endfunction

   function automatic int censor_len();
      return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
   endfunction

   function automatic logic [CHAR_W-1:0] pattern_byte(int k);
      return (k < 8) ? pat_low[8*k +: 8] : pat_high[8*(k-8) +: 8];
   endfunction

   function automatic rsp_type predict_censor(logic [ACTION_W-1:0] action,
                                               logic [CHAR_W-1:0] ch,
                                               logic [POS_W-1:0] pos);
      rsp_type r;
      int len;
      int base;
      bit hit;
      r = '0;
      case (action)
         ACT_PUSH: begin
            if (kept_total >= STACK_SIZE) begin
               r.overflow = 1'b1;
               predicted_overflows++;
            end else begin
               len = censor_len();
               kept_store[kept_total] = ch;
               kept_total++;
               if (len > 0 && kept_total >= len) begin
                  base = kept_total - len;
                  hit = 1'b1;
                  for (int k = 0; k < len; k++)
                     if (kept_store[base + k] != pattern_byte(k))
                        hit = 1'b0;
                  if (hit) begin
                     kept_total = base;
                     r.removed = 1'b1;
                     predicted_removals++;
                  end
               end
            end
         end
         ACT_READ: begin
            if (int'(pos) < kept_total) begin
               r.read_valid = 1'b1;
               r.read_char = kept_store[pos];
               valid_reads++;
            end
         end
         ACT_CLEAR: begin
            kept_total = 0;
            clears_sent++;
         end
         default: ;
      endcase
      r.kept_length = kept_total[KEPT_W-1:0];
      return r;
   endfunction

   // next byte of a well-formed stream: patterns nested inside unfinished ones, some noise
   function automatic logic [CHAR_W-1:0] next_censor_byte();
      int len;
      int top;
      len = censor_len();
      if (len == 0 || $urandom_range(9) == 0)
         return CHAR_W'($urandom_range(255));
      if (open_matches.size() == 0 || (open_matches.size() < 4 && $urandom_range(4) == 0))
         open_matches.push_back(0);
      top = open_matches[$];
      open_matches.delete(open_matches.size() - 1);
      if (top + 1 < len)
         open_matches.push_back(top + 1);
      return pattern_byte(top);
   endfunction

   function automatic void add_request(logic [ACTION_W-1:0] action, logic [CHAR_W-1:0] ch,
                                       logic [POS_W-1:0] pos);
      directed_row_type row;
      row = '0;
      row.kind = ROW_REQUEST;
      row.action = action;
      row.char_value = ch;
      row.position = pos;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(logic [ACTION_W-1:0] action, logic [CHAR_W-1:0] ch,
                                       logic [POS_W-1:0] pos, int kept, bit rem,
                                       logic [CHAR_W-1:0] rchar, bit rvalid, bit ovf);
      directed_row_type row;
      row = '0;
      row.kind = ROW_REQUEST;
      row.action = action;
      row.char_value = ch;
      row.position = pos;
      row.typed = 1'b1;
      row.want.kept_length = kept[KEPT_W-1:0];
      row.want.removed = rem;
      row.want.read_char = rchar;
      row.want.read_valid = rvalid;
      row.want.overflow = ovf;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_register(logic [1:0] idx, logic [63:0] value);
      directed_row_type row;
      row = '0;
      row.kind = ROW_REGISTER;
      row.reg_idx = idx;
      row.reg_value = value;
      directed_rows.push_back(row);
   endfunction

   task automatic send_request(logic [ACTION_W-1:0] action, logic [CHAR_W-1:0] ch,
                               logic [POS_W-1:0] pos, bit typed, rsp_type typed_rsp);
      rsp_type predicted;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.action <= action;
      req_ch.char_value <= ch;
      req_ch.position <= pos;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      predicted = predict_censor(action, ch, pos);
      expected_rsp_q.push_back(typed ? typed_rsp : predicted);
      requests_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   // write one register while the block is idle, then read it back
   task automatic write_register(logic [1:0] idx, logic [63:0] value);
      logic [63:0] stored;
      wait_drained();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      case (idx)
         REG_PATTERN_LENGTH: begin
            pat_len = value[LEN_W-1:0];
            stored = {{(64-LEN_W){1'b0}}, value[LEN_W-1:0]};
         end
         REG_PATTERN_LOW: begin
            pat_low = value;
            stored = value;
         end
         default: begin
            pat_high = value;
            stored = value;
         end
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (csr_prdata !== stored)
         note_failure($sformatf("register %0d read back %h, wrote %h", idx, csr_prdata, stored));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_random_request();
      int roll;
      logic [POS_W-1:0] pos;
      roll = $urandom_range(99);
      pos = POS_W'($urandom_range(4095));
      if (roll < 72) begin
         send_request(ACT_PUSH, next_censor_byte(), pos, 1'b0, '0);
      end else if (roll < 93) begin
         if (kept_total > 0 && $urandom_range(3) != 0)
            pos = POS_W'($urandom_range(kept_total - 1));
         send_request(ACT_READ, CHAR_W'($urandom_range(255)), pos, 1'b0, '0);
      end else if (roll < 96) begin
         send_request(ACT_UNUSED, CHAR_W'($urandom_range(255)), pos, 1'b0, '0);
      end else begin
         send_request(ACT_CLEAR, CHAR_W'($urandom_range(255)), pos, 1'b0, '0);
         open_matches.delete();
      end
   endtask

   task automatic run_censor_segment(int count, int stall_at, int pause_at);
      open_matches.delete();
      for (int n = 0; n < count; n++) begin
         if (n == stall_at)
            -> start_long_stall;
         if (n == pause_at)
            wait_drained();
         send_random_request();
      end
   endtask

   // long hold-off on the result side, counted here so the sender keeps offering
   initial begin
      long_stall = 1'b0;
      forever begin
         @(start_long_stall);
         long_stall = 1'b1;
         repeat (LONG_STALL_CYCLES) @(posedge clock);
         long_stall = 1'b0;
      end
   end

   always @(negedge clock)
      rsp_ch.ready <= !long_stall && (recv_idle_pct == 0 || $urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsp_q.size() == 0) begin
            note_failure($sformatf("result with no request pending, kept_length %0d",
                                   rsp_ch.kept_length));
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_ch.kept_length !== want.kept_length || rsp_ch.removed !== want.removed ||
                rsp_ch.read_char !== want.read_char || rsp_ch.read_valid !== want.read_valid ||
                rsp_ch.overflow !== want.overflow)
               note_failure({
                  $sformatf("result %0d: expected kept %0d rem %0b char %h rv %0b ovf %0b",
                            results_checked, want.kept_length, want.removed,
                            want.read_char, want.read_valid, want.overflow),
                  $sformatf(", got kept %0d rem %0b char %h rv %0b ovf %0b",
                            rsp_ch.kept_length, rsp_ch.removed, rsp_ch.read_char,
                            rsp_ch.read_valid, rsp_ch.overflow)});
         end
         results_checked++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_rsp_q.size());
         $display("stream_pattern_censor test failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_PUSH;
      req_ch.char_value = '0;
      req_ch.position = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      kept_total = 0;
      pat_len = 5'd1;
      pat_low = '0;
      pat_high = '0;
      mismatch_count = 0;
      results_checked = 0;
      requests_sent = 0;
      predicted_removals = 0;
      predicted_overflows = 0;
      valid_reads = 0;
      clears_sent = 0;
      send_idle_pct = 15;
      recv_idle_pct = 60;

      // reset pattern is a single zero byte
      add_checked(ACT_PUSH, 8'h00, 12'h000, 0, 1'b1, 8'h00, 1'b0, 1'b0);
      add_checked(ACT_PUSH, 8'hFF, 12'hFFF, 1, 1'b0, 8'h00, 1'b0, 1'b0);
      add_checked(ACT_READ, 8'hFF, 12'h000, 1, 1'b0, 8'hFF, 1'b1, 1'b0);
      add_checked(ACT_READ, 8'h00, 12'h001, 1, 1'b0, 8'h00, 1'b0, 1'b0);
      add_checked(ACT_READ, 8'h00, 12'hFFF, 1, 1'b0, 8'h00, 1'b0, 1'b0);
      add_checked(ACT_UNUSED, 8'hFF, 12'hFFF, 1, 1'b0, 8'h00, 1'b0, 1'b0);
      add_checked(ACT_CLEAR, 8'hFF, 12'hFFF, 0, 1'b0, 8'h00, 1'b0, 1'b0);
      add_checked(ACT_READ, 8'h00, 12'h000, 0, 1'b0, 8'h00, 1'b0, 1'b0);
      // zero length: nothing is ever removed
      add_register(REG_PATTERN_LENGTH, 64'd0);
      add_checked(ACT_PUSH, 8'h00, 12'h000, 1, 1'b0, 8'h00, 1'b0, 1'b0);
      // "abc" with a removal that exposes a second occurrence
      add_register(REG_PATTERN_LOW, 64'h0000_0000_0063_6261);
      add_register(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      add_register(REG_PATTERN_LENGTH, 64'd3);
      add_request(ACT_PUSH, 8'h61, 12'h000);
      add_request(ACT_PUSH, 8'h62, 12'h000);
      add_request(ACT_PUSH, 8'h61, 12'h000);
      add_request(ACT_PUSH, 8'h62, 12'h000);
      add_request(ACT_PUSH, 8'h63, 12'h000);
      add_request(ACT_PUSH, 8'h63, 12'h000);
      add_request(ACT_READ, 8'h00, 12'h000);
      add_request(ACT_READ, 8'h00, 12'h001);
      // length above the maximum saturates
      add_register(REG_PATTERN_LENGTH, 64'd31);
      add_request(ACT_PUSH, 8'h61, 12'h000);
      add_request(ACT_PUSH, 8'h62, 12'h000);
      add_request(ACT_PUSH, 8'h63, 12'h000);
      add_request(ACT_CLEAR, 8'h00, 12'h000);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REGISTER)
            write_register(directed_rows[i].reg_idx, directed_rows[i].reg_value);
         else
            send_request(directed_rows[i].action, directed_rows[i].char_value,
                         directed_rows[i].position, directed_rows[i].typed,
                         directed_rows[i].want);
      end

      // sender rarely idle, receiver often stalled; one long receiver stall
      write_register(REG_PATTERN_LOW, {$urandom, $urandom});
      write_register(REG_PATTERN_HIGH, {$urandom, $urandom});
      write_register(REG_PATTERN_LENGTH, 64'd2);
      run_censor_segment(110, 40, -1);

      send_idle_pct = 60;
      recv_idle_pct = 15;
      write_register(REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      write_register(REG_PATTERN_LENGTH, 64'd31);
      run_censor_segment(110, -1, -1);

      write_register(REG_PATTERN_LOW, {$urandom, $urandom});
      write_register(REG_PATTERN_HIGH, {$urandom, $urandom});
      write_register(REG_PATTERN_LENGTH, 64'd16);
      run_censor_segment(110, -1, 55);

      // no idling from here on; zero length, then a single-byte pattern
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(REG_PATTERN_LENGTH, 64'd0);
      send_request(ACT_CLEAR, 8'h00, 12'h000, 1'b0, '0);
      send_request(ACT_PUSH, 8'hA5, 12'h000, 1'b0, '0);
      send_request(ACT_READ, 8'h00, 12'hFFF, 1'b0, '0);
      send_request(ACT_READ, 8'h00, POS_W'($urandom_range(4095)), 1'b0, '0);
      write_register(REG_PATTERN_LENGTH, 64'd1);
      send_request(ACT_PUSH, pattern_byte(0), 12'h000, 1'b0, '0);
      send_request(ACT_CLEAR, 8'h00, 12'h000, 1'b0, '0);

      write_register(REG_PATTERN_LOW, {$urandom, $urandom});
      write_register(REG_PATTERN_HIGH, {$urandom, $urandom});
      write_register(REG_PATTERN_LENGTH, 64'($urandom_range(15, 1)));
      run_censor_segment(110, -1, -1);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d requests and %0d results: %0d removals, %0d overflows",
               requests_sent, results_checked, predicted_removals, predicted_overflows);
      $display("%0d in-range reads, %0d clears, pattern lengths 0 to 31, %0d mismatches",
               valid_reads, clears_sent, mismatch_count);
      if (mismatch_count == 0)
         $display("stream_pattern_censor test passed");
      else
         $display("stream_pattern_censor test failed");
      $finish;
   end

endmodule
